### rtl/mdss_pkg.sv
// Shared constants, types and the digit decoder for the seven-segment driver.
package mdss_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  localparam int unsigned DIGITS_DEF = 4;
  localparam int unsigned VALUE_W    = 14;
  localparam int unsigned PASS_W     = 16;
  localparam int unsigned ANODE_W    = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned BCD_W      = 4;
  // A 14-bit value has at most five decimal digits
  localparam int unsigned VALUE_DIGITS = 5;

  // Reciprocal multipliers: floor(v * RECIP[k] >> SHIFT[k]) == v / 10**k for any 14-bit v
  localparam int unsigned PROD_W = 30;
  localparam logic [VALUE_DIGITS-1:1][15:0] RECIP = {16'd13422, 16'd16778, 16'd5243, 16'd52429};
  localparam logic [VALUE_DIGITS-1:1][4:0]  SHIFT = {5'd27, 5'd24, 5'd19, 5'd19};

  localparam logic [ANODE_W-1:0] ANODE_BLANK = '1;
  localparam logic [SEG_W-1:0]   SEG_BLANK   = '1;

  typedef logic [BCD_W-1:0] bcd_t;

  // Active-high segments a..g; codes above nine light nothing
  function automatic logic [6:0] seg7(input bcd_t d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3f;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5b;
      4'd3: s = 7'h4f;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6d;
      4'd6: s = 7'h7d;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7f;
      4'd9: s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

### rtl/multiplexed_decimal_seven_segment_top.sv
// Top level of the multiplexed decimal seven-segment display driver.
// Takes one item per clock while not stalled and answers each with exactly one result item,
// in the next cycle through the output register; a load splits the value into decimal
// digits with parallel constant-reciprocal multiplies and answers blank, and each
// tick selects the stored digit at the scan position and decodes it. The input
// channel stalls only while a result sits in the output register and the output
// side stalls, so with an open output side the rate is one item per cycle.
// Outputs are active low; the dot pin (segment bit 7) stays dark.
module multiplexed_decimal_seven_segment_top #(
  parameter int unsigned DIGITS = mdss_pkg::DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [mdss_pkg::VALUE_W-1:0]  value_i,
  input  logic [mdss_pkg::PASS_W-1:0]   pass_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mdss_pkg::ANODE_W-1:0]  anode_n_o,
  output logic [mdss_pkg::SEG_W-1:0]    segment_n_o
);
  import mdss_pkg::*;

  localparam int unsigned SW = $clog2(DIGITS + 1);
  localparam int unsigned PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DIGITS - 1);

  // Display state
  bcd_t [DIGITS-1:0]  digit_q, digit_d;
  logic [SW-1:0]      sig_q, sig_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [PASS_W-1:0]  passes_q, passes_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [ANODE_W-1:0] anode_q, anode_d;
  logic [SEG_W-1:0]   segment_q, segment_d;

  bcd_t [DIGITS-1:0]  split_digits;
  logic [SW-1:0]      split_sig;
  logic               accept;
  logic               is_load;
  logic               active;
  logic               lit;
  bcd_t               cur_digit;

  mdss_split #(
    .DIGITS(DIGITS)
  ) u_split (
    .value_i (value_i),
    .digits_o(split_digits),
    .sig_o   (split_sig)
  );

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_load     = (kind_e'(kind_i) == KIND_LOAD);
  assign out_valid_o = out_valid_q;
  assign anode_n_o   = anode_q;
  assign segment_n_o = segment_q;

  // Tick decode
  assign active    = (passes_q != '0);
  assign cur_digit = digit_q[pos_q];
  assign lit       = active && (SW'(pos_q) < sig_q);

  // Next state and result
  always_comb begin
    digit_d     = digit_q;
    sig_d       = sig_q;
    pos_d       = pos_q;
    passes_d    = passes_q;
    out_valid_d = out_valid_q && out_stall_i;
    anode_d     = anode_q;
    segment_d   = segment_q;
    if (accept) begin
      out_valid_d = 1'b1;
      anode_d     = ANODE_BLANK;
      segment_d   = SEG_BLANK;
      if (is_load) begin
        digit_d  = split_digits;
        sig_d    = split_sig;
        pos_d    = '0;
        passes_d = pass_count_i;
      end else if (active) begin
        if (lit) begin
          // positions past the anode pins shift out and stay dark
          anode_d   = ~(ANODE_W'(1) << pos_q);
          segment_d = ~{1'b0, seg7(cur_digit)};
        end
        if (pos_q == LAST_POS) begin
          pos_d    = '0;
          passes_d = passes_q - PASS_W'(1);
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q     <= '0;
      sig_q       <= '0;
      pos_q       <= '0;
      passes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      digit_q     <= digit_d;
      sig_q       <= sig_d;
      pos_q       <= pos_d;
      passes_q    <= passes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    anode_q   <= anode_d;
    segment_q <= segment_d;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < DIGITS)
    else $error("scan position beyond digit count");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sig_q) <= DIGITS)
    else $error("significant digit count too large");

  a_one_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot0(~anode_n_o) && segment_n_o[SEG_W-1]))
    else $error("more than one anode lit or dot lit");

  a_load_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> (anode_n_o == ANODE_BLANK && segment_n_o == SEG_BLANK))
    else $error("load item did not answer blank");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_load && !active) |=> ($stable(pos_q) && passes_q == '0))
    else $error("scan moved with no passes left");
`endif

endmodule

### rtl/mdss_split.sv
// Splits a binary value into decimal digits and counts the significant ones.
module mdss_split #(
  parameter int unsigned DIGITS = mdss_pkg::DIGITS_DEF
) (
  input  logic [mdss_pkg::VALUE_W-1:0]           value_i,
  output mdss_pkg::bcd_t [DIGITS-1:0]            digits_o,
  output logic [$clog2(DIGITS+1)-1:0]            sig_o
);
  import mdss_pkg::*;

  localparam int unsigned SW = $clog2(DIGITS + 1);

  logic [VALUE_DIGITS-1:0][VALUE_W-1:0] quot;
  logic [DIGITS-1:0]                    nonzero;

  // Quotients by powers of ten, all in parallel
  assign quot[0] = value_i;
  for (genvar k = 1; k < VALUE_DIGITS; k++) begin : g_quot
    logic [PROD_W-1:0] prod;
    assign prod    = PROD_W'(value_i) * PROD_W'(RECIP[k]);
    assign quot[k] = VALUE_W'(prod >> SHIFT[k]);
  end

  // Digit k is quot[k] minus ten times quot[k+1]
  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    if (k < VALUE_DIGITS - 1) begin : g_mid
      logic [VALUE_W-1:0] rem;
      assign rem         = quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1));
      assign digits_o[k] = rem[BCD_W-1:0];
      assign nonzero[k]  = (quot[k] != '0);
    end else if (k == VALUE_DIGITS - 1) begin : g_top
      assign digits_o[k] = quot[k][BCD_W-1:0];
      assign nonzero[k]  = (quot[k] != '0);
    end else begin : g_none
      assign digits_o[k] = '0;
      assign nonzero[k]  = 1'b0;
    end
  end

  // Quotients shrink with k, so the count of nonzero ones is the digit count
  always_comb begin
    sig_o = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (nonzero[i]) begin
        sig_o = sig_o + SW'(1);
      end
    end
  end

endmodule

### verif/tb_multiplexed_decimal_seven_segment_top.sv
// Self-checking testbench for the multiplexed decimal seven-segment driver.
module tb_multiplexed_decimal_seven_segment_top;
  import mdss_pkg::*;

  localparam int unsigned NDIG        = DIGITS_DEF;
  localparam int unsigned ITEMS       = 1500;
  localparam int unsigned PAUSE_AT    = 700;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYC   = 8;

  // Active-high segment patterns a..g for decimal digits
  localparam logic [6:0] DIGIT_SEGS [0:9] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h67
  };

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [PASS_W-1:0]  passes;
  } disp_item_t;

  typedef struct packed {
    logic [ANODE_W-1:0] anode_n;
    logic [SEG_W-1:0]   segment_n;
  } disp_out_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               kind_i       = KIND_TICK;
  logic [VALUE_W-1:0] value_i      = '0;
  logic [PASS_W-1:0]  pass_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [ANODE_W-1:0] anode_n_o;
  logic [SEG_W-1:0]   segment_n_o;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  multiplexed_decimal_seven_segment_top #(
    .DIGITS(NDIG)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .pass_count_i (pass_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .anode_n_o    (anode_n_o),
    .segment_n_o  (segment_n_o)
  );

  always #4 clk_i = ~clk_i;

  disp_item_t  pending_q [$];
  disp_out_t   expected_display_q [$];

  // Predictor state
  bcd_t              shown_digits [NDIG];
  int unsigned       lit_positions = 0;
  int unsigned       scan_pos      = 0;
  logic [PASS_W-1:0] passes_left   = '0;

  int unsigned load_count    = 0;
  int unsigned tick_count    = 0;
  int unsigned lit_count     = 0;
  int unsigned checked_count = 0;
  int unsigned stall_count   = 0;
  int unsigned mismatch_count = 0;
  int unsigned sent_count    = 0;
  int unsigned idle_cycles   = 0;

  // Expected display output for one accepted item; advances the scan state
  function automatic disp_out_t predict_display(disp_item_t it);
    disp_out_t   r;
    int unsigned rest;
    logic [6:0]  segs;
    r.anode_n   = ANODE_BLANK;
    r.segment_n = SEG_BLANK;
    if (it.kind == KIND_LOAD) begin
      rest          = it.value;
      lit_positions = 0;
      for (int i = 0; i < NDIG; i++) begin
        if (rest != 0) lit_positions = i + 1;
        shown_digits[i] = bcd_t'(rest % 10);
        rest = rest / 10;
      end
      scan_pos    = 0;
      passes_left = it.passes;
      load_count++;
    end else begin
      tick_count++;
      if (passes_left != 0) begin
        if (scan_pos < lit_positions && scan_pos < ANODE_W) begin
          segs = (shown_digits[scan_pos] <= 9) ? DIGIT_SEGS[shown_digits[scan_pos]] : 7'h00;
          r.anode_n   = ~(ANODE_W'(1) << scan_pos);
          r.segment_n = {1'b1, ~segs};
          lit_count++;
        end
        if (scan_pos + 1 >= NDIG) begin
          scan_pos    = 0;
          passes_left = passes_left - 1'b1;
        end else begin
          scan_pos = scan_pos + 1;
        end
      end
    end
    return r;
  endfunction

  // Driver: bursts of items with random gaps, one drain pause
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  bit          paused     = 1'b0;
  bit          pause_done = 1'b0;

  always @(posedge clk_i) begin : drive_proc
    bit         present;
    disp_item_t it;
    present = 1'b0;
    if (rst_ni) begin
      if (in_fire) begin
        expected_display_q.push_back(predict_display({kind_e'(kind_i), value_i,
                                                      pass_count_i}));
        sent_count++;
      end
      if (!in_valid_i || in_fire) begin
        if (!pause_done && sent_count == PAUSE_AT) begin
          paused     = 1'b1;
          pause_done = 1'b1;
        end
        if (paused) begin
          if (expected_display_q.size() == 0) paused = 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          it      = pending_q.pop_front();
          present = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid_i <= present;
        if (present) begin
          kind_i       <= it.kind;
          value_i      <= it.value;
          pass_count_i <= it.passes;
        end
      end
    end
  end

  // Monitor: compare each result against the oldest expectation; stall on a pattern
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin : monitor_proc
    bit        stall_next;
    disp_out_t want;
    stall_next = 1'b0;
    if (rst_ni) begin
      if (out_fire) begin
        checked_count++;
        if (expected_display_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: anode_n=%h segment_n=%h", anode_n_o, segment_n_o);
        end else begin
          want = expected_display_q.pop_front();
          if (want.anode_n !== anode_n_o || want.segment_n !== segment_n_o) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result %0d: expected anode_n=%h segment_n=%h, got anode_n=%h segment_n=%h",
                       checked_count, want.anode_n, want.segment_n, anode_n_o, segment_n_o);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(0, 2) == 0);
        2:       stall_next = 1'($urandom_range(0, 1));
        default: stall_next = ((stall_left % 16) < 12);
      endcase
      if (stall_next) stall_count++;
    end
    out_stall_i <= stall_next;
  end

  // Cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else                     idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d idle cycles", idle_cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_item(kind_e k, logic [VALUE_W-1:0] v, logic [PASS_W-1:0] p);
    pending_q.push_back({k, v, p});
  endtask

  task automatic push_ticks(int unsigned n);
    for (int i = 0; i < n; i++) push_item(KIND_TICK, VALUE_W'($urandom), PASS_W'($urandom));
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = VALUE_W'($urandom_range(1, 9));
      2:       v = VALUE_W'($urandom_range(10, 999));
      3:       v = VALUE_W'($urandom_range(1000, 9999));
      4:       v = VALUE_W'($urandom_range(10000, 16383));
      default: v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [PASS_W-1:0] rand_passes();
    logic [PASS_W-1:0] p;
    case ($urandom_range(0, 7))
      0:       p = '0;
      1:       p = PASS_W'($urandom);
      default: p = PASS_W'($urandom_range(1, 3));
    endcase
    return p;
  endfunction

  // Stimulus and end of run
  initial begin : stimulus
    logic [PASS_W-1:0] p;
    int unsigned       n;
    // Tick right after reset, with no passes left
    push_ticks(1);
    // Zero shows nothing
    push_item(KIND_LOAD, 14'd0, 16'd1);
    push_ticks(4);
    // All nines, then a tick after the passes ran out
    push_item(KIND_LOAD, 14'd9999, 16'd1);
    push_ticks(5);
    push_item(KIND_LOAD, 14'd8765, 16'd1);
    push_ticks(4);
    // Values above the range keep only the low digits, all significant
    push_item(KIND_LOAD, 14'd10000, 16'd1);
    push_ticks(4);
    // Largest value and pass count, reloaded mid-pass
    push_item(KIND_LOAD, 14'h3fff, 16'hffff);
    push_ticks(2);

    // Random part: mostly loads followed by ticks, some noise
    while (pending_q.size() < ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        push_item(kind_e'($urandom_range(0, 1)), VALUE_W'($urandom), PASS_W'($urandom));
      end else begin
        p = rand_passes();
        push_item(KIND_LOAD, rand_value(), p);
        n = (p > 4) ? $urandom_range(0, 16) : $urandom_range(0, 4 * p + 3);
        push_ticks(n);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_display_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk_i);

    if (expected_display_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_display_q.size());
      mismatch_count += expected_display_q.size();
    end
    $display("Drove %0d loads and %0d ticks, %0d of them lighting a digit; %0d results checked.",
             load_count, tick_count, lit_count, checked_count);
    $display("Output side stalled on %0d cycles; %0d mismatches.", stall_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mdss_pkg.sv
rtl/mdss_split.sv
rtl/multiplexed_decimal_seven_segment_top.sv
verif/tb_multiplexed_decimal_seven_segment_top.sv
